// ===== hw/rtl/multimodal_rope_position_ids_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multimodal rope position id block
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTIMODAL_ROPE_POSITION_IDS_ASSERT_SVH
`define MULTIMODAL_ROPE_POSITION_IDS_ASSERT_SVH

`define MROPE_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`define MROPE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/mrope_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimodal rope position id package
// Field widths, register codes, state encoding and the types shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package mrope_pkg;

  localparam int unsigned TOKEN_W      = 18;
  localparam int unsigned GRID_IN_W    = 11;
  localparam int unsigned POS_OUT_W    = 24;
  localparam int unsigned MERGE_W      = 4;
  localparam int unsigned CFG_DATA_W   = 18;
  localparam int unsigned POS_BITS_DEF = 24;
  localparam int unsigned GRID_MAX_DEF = 1024;

  localparam logic [TOKEN_W-1:0] IMAGE_TOKEN_RST = 18'd151655;
  localparam logic [MERGE_W-1:0] MERGE_RST       = 4'd2;

  typedef enum logic [0:0] {
    CFG_IMAGE_TOKEN = 1'b0,
    CFG_MERGE_SIZE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_DIV  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [TOKEN_W-1:0]   token_code;
    logic                 grid_present;
    logic [GRID_IN_W-1:0] grid_frames;
    logic [GRID_IN_W-1:0] grid_rows;
    logic [GRID_IN_W-1:0] grid_cols;
  } tok_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] pos_temporal;
    logic [POS_OUT_W-1:0] pos_height;
    logic [POS_OUT_W-1:0] pos_width;
    logic                 is_image_patch;
  } pos_t;

  typedef struct packed {
    logic take_item;
    logic start_div;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic img_start;
    logic div_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/mrope_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimodal rope position id channels
// Token input, position output and configuration write channels.
// ----------------------------------------------------------------------------
interface mrope_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mrope_pkg::TOKEN_W-1:0]        token_code;
  logic                                 grid_present;
  logic [mrope_pkg::GRID_IN_W-1:0]      grid_frames;
  logic [mrope_pkg::GRID_IN_W-1:0]      grid_rows;
  logic [mrope_pkg::GRID_IN_W-1:0]      grid_cols;

  modport source (output valid, token_code, grid_present, grid_frames, grid_rows, grid_cols,
                  input ready);
  modport sink (input valid, token_code, grid_present, grid_frames, grid_rows, grid_cols,
                output ready);
endinterface

interface mrope_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mrope_pkg::POS_OUT_W-1:0]      pos_temporal;
  logic [mrope_pkg::POS_OUT_W-1:0]      pos_height;
  logic [mrope_pkg::POS_OUT_W-1:0]      pos_width;
  logic                                 is_image_patch;

  modport source (output valid, pos_temporal, pos_height, pos_width, is_image_patch,
                  input ready);
  modport sink (input valid, pos_temporal, pos_height, pos_width, is_image_patch,
                output ready);
endinterface

interface mrope_cfg_if;
  logic                                 valid;
  logic                                 ready;
  mrope_pkg::cfg_idx_e                  index;
  logic [mrope_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mrope_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimodal rope grid divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrope_div #(
  parameter int unsigned GRID_W = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [GRID_W-1:0]             dividend_i,
  input  logic [mrope_pkg::MERGE_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic [GRID_W-1:0]             quotient_o
);

  localparam int unsigned CNT_W = $clog2(GRID_W + 1);
  localparam int unsigned MW    = mrope_pkg::MERGE_W;

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [GRID_W-1:0] quo_q, quo_d;
  logic [MW-1:0]     rem_q, rem_d;
  logic [MW-1:0]     div_q, div_d;
  logic [MW:0]       rem_sh;
  logic [MW:0]       rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[GRID_W-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = rem_sh - {1'b0, div_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(GRID_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[GRID_W-2:0], ge};
      rem_d = ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/mrope_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimodal rope position id controller
// Handshake control, divider sequencing and output register occupancy.
// ----------------------------------------------------------------------------
module mrope_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  input  mrope_pkg::dp_status_t status_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output mrope_pkg::dp_cmd_t    cmd_o
);

  mrope_pkg::ctrl_state_e state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;

  always_comb begin
    out_free        = !out_valid_q || out_ready_i;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      mrope_pkg::S_IDLE: begin
        in_ready_o      = out_free;
        cmd_o.take_item = in_valid_i && out_free && !status_i.img_start;
        cmd_o.start_div = in_valid_i && out_free && status_i.img_start;
      end
      mrope_pkg::S_DIV: begin
        cmd_o.finish = !status_i.div_busy && out_free;
      end
    endcase
    if (cmd_o.take_item || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrope_pkg::S_IDLE: begin
        if (cmd_o.start_div) begin
          state_d = mrope_pkg::S_DIV;
        end
      end
      mrope_pkg::S_DIV: begin
        if (cmd_o.finish) begin
          state_d = mrope_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrope_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/mrope_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimodal rope position id datapath
// Configuration registers, position base, run counters and output register.
// ----------------------------------------------------------------------------
module mrope_dp #(
  parameter int unsigned POS_BITS = mrope_pkg::POS_BITS_DEF,
  parameter int unsigned GRID_MAX = mrope_pkg::GRID_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  mrope_pkg::cfg_idx_e              cfg_index_i,
  input  logic [mrope_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  mrope_pkg::tok_t                  tok_i,
  input  mrope_pkg::dp_cmd_t               cmd_i,
  output mrope_pkg::dp_status_t            status_o,
  output mrope_pkg::pos_t                  pos_o
);

  localparam int unsigned GRID_W = $clog2(GRID_MAX + 1);
  localparam int unsigned MW     = mrope_pkg::MERGE_W;
  localparam int unsigned OW     = mrope_pkg::POS_OUT_W;

  function automatic logic [GRID_W-1:0] clamp_grid(
    input logic [mrope_pkg::GRID_IN_W-1:0] v
  );
    logic [GRID_W-1:0] r;
    if (32'(v) > GRID_MAX) begin
      r = GRID_W'(GRID_MAX);
    end else begin
      r = GRID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_add(
    input logic [POS_BITS-1:0] a,
    input logic [GRID_W-1:0]   b
  );
    logic [POS_BITS:0] s;
    s = {1'b0, a} + (POS_BITS + 1)'(b);
    return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
  endfunction

  logic [mrope_pkg::TOKEN_W-1:0] image_code_q, image_code_d;
  logic [MW-1:0]                 merge_q, merge_d;
  logic [POS_BITS-1:0]           next_base_q, next_base_d;
  logic [POS_BITS-1:0]           run_base_q, run_base_d;
  logic                          in_run_q, in_run_d;
  logic [GRID_W-1:0]             frame_q, frame_d;
  logic [GRID_W-1:0]             row_q, row_d;
  logic [GRID_W-1:0]             col_q, col_d;
  logic [GRID_W-1:0]             run_frames_q, run_frames_d;
  logic [GRID_W-1:0]             run_rows_q, run_rows_d;
  logic [GRID_W-1:0]             run_cols_q, run_cols_d;
  logic [GRID_W-1:0]             grid_t_q;
  mrope_pkg::pos_t               pos_q, pos_d;

  logic [MW-1:0]       m_eff;
  logic [GRID_W-1:0]   t_in, h_in, w_in;
  logic [GRID_W-1:0]   gh, gw, ext;
  logic                busy_h, busy_w;
  logic                empty, run_go, run_more, load;
  logic [POS_BITS-1:0] ext_base, text_base, text_inc, b;
  logic [GRID_W-1:0]   fi, ri, ci, nf, nr, nc;
  logic [GRID_W-1:0]   frm_p, row_p, col_p, frm_n, row_n, col_n;

  always_comb begin
    m_eff = (merge_q == '0) ? MW'(1) : merge_q;
    t_in  = clamp_grid(tok_i.grid_frames);
    h_in  = clamp_grid(tok_i.grid_rows);
    w_in  = clamp_grid(tok_i.grid_cols);
    status_o.img_start = !in_run_q && (tok_i.token_code == image_code_q) && tok_i.grid_present;
    status_o.div_busy  = busy_h || busy_w;
  end

  mrope_div #(.GRID_W(GRID_W)) u_div_rows (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (h_in),
    .divisor_i  (m_eff),
    .busy_o     (busy_h),
    .quotient_o (gh)
  );

  mrope_div #(.GRID_W(GRID_W)) u_div_cols (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (w_in),
    .divisor_i  (m_eff),
    .busy_o     (busy_w),
    .quotient_o (gw)
  );

  always_comb begin
    ext = grid_t_q;
    if (gh > ext) begin
      ext = gh;
    end
    if (gw > ext) begin
      ext = gw;
    end
    empty     = (grid_t_q == '0) || (gh == '0) || (gw == '0);
    ext_base  = sat_add(next_base_q, ext);
    run_go    = cmd_i.finish ? !empty : in_run_q;
    b         = cmd_i.finish ? next_base_q : run_base_q;
    fi        = cmd_i.finish ? '0 : frame_q;
    ri        = cmd_i.finish ? '0 : row_q;
    ci        = cmd_i.finish ? '0 : col_q;
    nf        = cmd_i.finish ? grid_t_q : run_frames_q;
    nr        = cmd_i.finish ? gh : run_rows_q;
    nc        = cmd_i.finish ? gw : run_cols_q;
    text_base = cmd_i.finish ? ext_base : next_base_q;
    text_inc  = sat_add(text_base, GRID_W'(1));

    frm_p    = fi + GRID_W'(1);
    row_p    = ri + GRID_W'(1);
    col_p    = ci + GRID_W'(1);
    frm_n    = fi;
    row_n    = ri;
    col_n    = col_p;
    run_more = 1'b1;
    if (col_p >= nc) begin
      col_n = '0;
      row_n = row_p;
      if (row_p >= nr) begin
        row_n = '0;
        frm_n = frm_p;
        if (frm_p >= nf) begin
          frm_n    = '0;
          run_more = 1'b0;
        end
      end
    end

    load         = cmd_i.take_item || cmd_i.finish;
    pos_d        = pos_q;
    next_base_d  = next_base_q;
    run_base_d   = run_base_q;
    in_run_d     = in_run_q;
    frame_d      = frame_q;
    row_d        = row_q;
    col_d        = col_q;
    run_frames_d = run_frames_q;
    run_rows_d   = run_rows_q;
    run_cols_d   = run_cols_q;

    if (cmd_i.finish) begin
      run_base_d  = next_base_q;
      next_base_d = ext_base;
      if (!empty) begin
        run_frames_d = grid_t_q;
        run_rows_d   = gh;
        run_cols_d   = gw;
      end
    end

    if (load) begin
      if (run_go) begin
        pos_d.pos_temporal   = OW'(sat_add(b, fi));
        pos_d.pos_height     = OW'(sat_add(b, ri));
        pos_d.pos_width      = OW'(sat_add(b, ci));
        pos_d.is_image_patch = 1'b1;
        frame_d              = frm_n;
        row_d                = row_n;
        col_d                = col_n;
        in_run_d             = run_more;
      end else begin
        pos_d.pos_temporal   = OW'(text_base);
        pos_d.pos_height     = OW'(text_base);
        pos_d.pos_width      = OW'(text_base);
        pos_d.is_image_patch = 1'b0;
        next_base_d          = text_inc;
      end
    end
  end

  always_comb begin
    image_code_d = image_code_q;
    merge_d      = merge_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mrope_pkg::CFG_IMAGE_TOKEN: image_code_d = cfg_data_i[mrope_pkg::TOKEN_W-1:0];
        mrope_pkg::CFG_MERGE_SIZE:  merge_d      = cfg_data_i[MW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_code_q <= mrope_pkg::IMAGE_TOKEN_RST;
      merge_q      <= mrope_pkg::MERGE_RST;
      next_base_q  <= '0;
      run_base_q   <= '0;
      in_run_q     <= 1'b0;
      frame_q      <= '0;
      row_q        <= '0;
      col_q        <= '0;
      run_frames_q <= '0;
      run_rows_q   <= '0;
      run_cols_q   <= '0;
    end else begin
      image_code_q <= image_code_d;
      merge_q      <= merge_d;
      next_base_q  <= next_base_d;
      run_base_q   <= run_base_d;
      in_run_q     <= in_run_d;
      frame_q      <= frame_d;
      row_q        <= row_d;
      col_q        <= col_d;
      run_frames_q <= run_frames_d;
      run_rows_q   <= run_rows_d;
      run_cols_q   <= run_cols_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.start_div) begin
      grid_t_q <= t_in;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== hw/rtl/multimodal_rope_position_ids.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimodal rope position ids
// Gives one temporal, height and width position triple for every token.
// ----------------------------------------------------------------------------
// Text tokens and tokens inside an image run are taken one per cycle while
// the output register drains. A token that opens an image run holds the input
// while the grid rows and columns are divided by the merge factor in two
// bit-serial dividers that produce one quotient bit per cycle. Settings must
// be written only while no token is in flight; the block itself does not
// enforce this. There is no start-up pass.
`include "multimodal_rope_position_ids_assert.svh"

module multimodal_rope_position_ids #(
  parameter int unsigned POS_BITS = mrope_pkg::POS_BITS_DEF,
  parameter int unsigned GRID_MAX = mrope_pkg::GRID_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrope_cfg_if.sink   cfg_i,
  mrope_in_if.sink    tok_i,
  mrope_out_if.source pos_o
);

  mrope_pkg::tok_t       tok;
  mrope_pkg::pos_t       pos;
  mrope_pkg::dp_cmd_t    cmd;
  mrope_pkg::dp_status_t status;
  logic                  in_ready;
  logic                  out_valid;

  assign cfg_i.ready      = 1'b1;
  assign tok.token_code   = tok_i.token_code;
  assign tok.grid_present = tok_i.grid_present;
  assign tok.grid_frames  = tok_i.grid_frames;
  assign tok.grid_rows    = tok_i.grid_rows;
  assign tok.grid_cols    = tok_i.grid_cols;

  mrope_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tok_i.valid),
    .out_ready_i (pos_o.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  mrope_dp #(
    .POS_BITS (POS_BITS),
    .GRID_MAX (GRID_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .tok_i       (tok),
    .cmd_i       (cmd),
    .status_o    (status),
    .pos_o       (pos)
  );

  assign tok_i.ready          = in_ready;
  assign pos_o.valid          = out_valid;
  assign pos_o.pos_temporal   = pos.pos_temporal;
  assign pos_o.pos_height     = pos.pos_height;
  assign pos_o.pos_width      = pos.pos_width;
  assign pos_o.is_image_patch = pos.is_image_patch;

  `MROPE_ASSERT_NEXT(a_div_stalls_input, cmd.start_div, !tok_i.ready && status.div_busy, "input not stalled while dividing")
  `MROPE_ASSERT_IMPL(a_no_overwrite, pos_o.valid && !pos_o.ready, !(cmd.take_item || cmd.finish), "held result overwritten")
  `MROPE_ASSERT_NEXT(a_load_shows_result, cmd.take_item || cmd.finish, pos_o.valid, "loaded result not offered")

endmodule
